/* design/spdte_pkg.sv */
`default_nettype none
package spdte_pkg;

   localparam logic [7:0] START_BYTE   = 8'hFB;
   localparam logic [7:0] END_BYTE     = 8'hFE;
   localparam logic [7:0] TIME_DEFAULT = 8'd88;
   localparam logic [7:0] MODEL_RESET  = 8'd7;
   localparam logic [7:0] FORMAT_RESET = 8'd0;
   localparam logic [7:0] HELD_RESET   = 8'd0;

   localparam logic [4:0] POS_FIRST    = 5'd0;
   localparam logic [4:0] POS_PAGE     = 5'd3;
   localparam logic [4:0] POS_MINUTES  = 5'd4;
   localparam logic [4:0] POS_MODEL    = 5'd14;
   localparam logic [4:0] POS_FORMAT   = 5'd16;
   localparam logic [4:0] POS_HOURS    = 5'd18;
   localparam logic [4:0] POS_SUM_LAST = 5'd19;
   localparam logic [4:0] POS_CHECK    = 5'd20;
   localparam logic [4:0] POS_LAST     = 5'd21;

   localparam logic [7:0] PAGE_MODEL   = 8'd0;
   localparam logic [7:0] PAGE_HOURS   = 8'd5;
   localparam logic [7:0] PAGE_MINUTES = 8'd6;
   localparam logic [7:0] PAGE_FORMAT  = 8'd19;

   typedef enum logic [2:0] {
      STATUS_NONE     = 3'd0,
      STATUS_ACCEPTED = 3'd1,
      STATUS_BAD_END  = 3'd2,
      STATUS_BAD_SUM  = 3'd3,
      STATUS_MISMATCH = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] page;
      logic [7:0] model_byte;
      logic [7:0] minutes_byte;
      logic [7:0] format_byte;
      logic [7:0] hours_byte;
      logic [7:0] sum;
      logic [7:0] check;
   } page_fields_type;

   typedef struct packed {
      status_type status;
      logic       accept;
      logic       load_model;
      logic       load_hours;
      logic       load_minutes;
      logic       load_format;
   } page_verdict_type;

endpackage
`default_nettype wire

/* design/spdte_page_check.sv */
`default_nettype none
module spdte_page_check (
   input  wire spdte_pkg::page_fields_type  fields,
   input  wire logic [7:0]                  end_byte,
   input  wire logic [7:0]                  held_model,
   input  wire logic [7:0]                  expected_model,
   output spdte_pkg::page_verdict_type      verdict
);
   import spdte_pkg::*;

   logic [7:0] sum_total;
   logic [7:0] model_next;
   logic       is_model_page;

   assign sum_total     = fields.sum + fields.check;
   assign is_model_page = (fields.page == PAGE_MODEL);
   assign model_next    = is_model_page ? fields.model_byte : held_model;

   always_comb begin
      verdict = '0;
      verdict.status = STATUS_NONE;
      if (end_byte != END_BYTE) begin
         verdict.status = STATUS_BAD_END;
      end else if (sum_total != 8'd0) begin
         verdict.status = STATUS_BAD_SUM;
      end else begin
         verdict.load_model = is_model_page;
         if (model_next != expected_model) begin
            verdict.status = STATUS_MISMATCH;
         end else begin
            verdict.status       = STATUS_ACCEPTED;
            verdict.accept       = 1'b1;
            verdict.load_hours   = (fields.page == PAGE_HOURS);
            verdict.load_minutes = (fields.page == PAGE_MINUTES);
            verdict.load_format  = (fields.page == PAGE_FORMAT);
         end
      end
   end

endmodule
`default_nettype wire

/* design/serial_page_deframer_time_extract_core.sv */
// Serial page deframer with time extraction.
// Request channel (req_valid/req_ready/req_rx_byte) takes one received serial
// byte per beat. Each request beat yields exactly one response beat on
// rsp_valid/rsp_ready carrying link state, the page status of that byte and
// the held time, model and connected values after the byte is applied.
// A 0xFB byte restarts the page at position 0; the byte at position 21 ends
// the page, which is then checked for end marker, checksum and model.
// Latency: the response appears the cycle after the request beat. Throughput
// is one byte per cycle while rsp_ready is high; only next-state logic of the
// page position, link state, page check and held values lies between them.
// The response register holds its beat while rsp_ready is low; req_ready
// then drops and no further byte is taken until the beat is delivered.
// csr_wr_en/csr_wr_data write the expected controller model, reset 7.
// Reset (synchronous, active high) returns the position to 0, hours and
// minutes to 88, the format byte, model and flags to 0, and empties the
// response register.
`default_nettype none
module serial_page_deframer_time_extract_core (
   input  wire  logic       clock,
   input  wire  logic       reset,
   input  wire  logic       req_valid,
   output logic             req_ready,
   input  wire  logic [7:0] req_rx_byte,
   output logic             rsp_valid,
   input  wire  logic       rsp_ready,
   output logic             rsp_link_active,
   output logic [2:0]       rsp_frame_status,
   output logic             rsp_timeout_clear,
   output logic [7:0]       rsp_hours,
   output logic [7:0]       rsp_minutes,
   output logic [7:0]       rsp_time_24h,
   output logic             rsp_connected,
   output logic [7:0]       rsp_controller_model,
   input  wire  logic       csr_wr_en,
   input  wire  logic [7:0] csr_wr_data
);
   import spdte_pkg::*;

   logic [7:0]       expected_ff;
   logic [4:0]       pos_ff, pos_in, pos_eff;
   page_fields_type  fields_ff, fields_in;
   logic [7:0]       hours_ff, minutes_ff, format_ff, model_ff;
   logic             connected_ff, active_ff, active_in;
   logic             rsp_valid_ff;
   status_type       status_ff, status_in;
   logic             clear_ff;
   logic             accept, page_end;
   page_verdict_type verdict;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign pos_eff   = (req_rx_byte == START_BYTE) ? POS_FIRST : pos_ff;
   assign page_end  = (pos_eff == POS_LAST);

   spdte_page_check u_check (
      .fields         (fields_ff),
      .end_byte       (req_rx_byte),
      .held_model     (model_ff),
      .expected_model (expected_ff),
      .verdict        (verdict)
   );

   always_comb begin
      fields_in = fields_ff;
      case (pos_eff)
         POS_PAGE:    fields_in.page       = req_rx_byte;
         POS_MINUTES: fields_in.minutes_byte = req_rx_byte;
         POS_MODEL:   fields_in.model_byte = req_rx_byte;
         POS_FORMAT:  fields_in.format_byte = req_rx_byte;
         POS_HOURS:   fields_in.hours_byte = req_rx_byte;
         POS_CHECK:   fields_in.check      = req_rx_byte;
         default:     fields_in.page       = fields_ff.page;
      endcase
      if (pos_eff == POS_MINUTES) begin
         fields_in.sum = req_rx_byte;
      end else if (pos_eff > POS_MINUTES && pos_eff <= POS_SUM_LAST) begin
         fields_in.sum = fields_ff.sum + req_rx_byte;
      end
   end

   always_comb begin
      pos_in    = page_end ? POS_FIRST : pos_eff + 5'd1;
      active_in = page_end ? 1'b0 : ((req_rx_byte == START_BYTE) || active_ff);
      status_in = page_end ? verdict.status : STATUS_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= MODEL_RESET;
      end else if (csr_wr_en) begin
         expected_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_FIRST;
         active_ff    <= 1'b0;
         connected_ff <= 1'b0;
         hours_ff     <= TIME_DEFAULT;
         minutes_ff   <= TIME_DEFAULT;
         format_ff    <= FORMAT_RESET;
         model_ff     <= HELD_RESET;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STATUS_NONE;
         clear_ff     <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff    <= pos_in;
            active_ff <= active_in;
            status_ff <= status_in;
            clear_ff  <= page_end && verdict.accept;
            if (page_end) begin
               if (verdict.accept)       connected_ff <= 1'b1;
               if (verdict.load_model)   model_ff     <= fields_ff.model_byte;
               if (verdict.load_hours)   hours_ff     <= fields_ff.hours_byte;
               if (verdict.load_minutes) minutes_ff   <= fields_ff.minutes_byte;
               if (verdict.load_format)  format_ff    <= fields_ff.format_byte;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // captured page bytes carry no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         fields_ff <= fields_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_link_active      = active_ff;
   assign rsp_frame_status     = status_ff;
   assign rsp_timeout_clear    = clear_ff;
   assign rsp_hours            = hours_ff;
   assign rsp_minutes          = minutes_ff;
   assign rsp_time_24h         = format_ff;
   assign rsp_connected        = connected_ff;
   assign rsp_controller_model = model_ff;

endmodule
`default_nettype wire

/* dv/tb_serial_page_deframer_time_extract_core.sv */
`default_nettype none
module tb_serial_page_deframer_time_extract_core;
   import spdte_pkg::*;

   localparam int PAGE_LEN    = 22;
   localparam int FILLER_POS  = 5;
   localparam int NUM_KINDS   = 8;
   localparam int CYCLE_LIMIT = 300000;

   typedef enum int {
      KIND_GOOD,
      KIND_BAD_END,
      KIND_BAD_SUM,
      KIND_WRONG_MODEL,
      KIND_NO_START,
      KIND_CUT_SHORT,
      KIND_START_AT_END,
      KIND_NOISE
   } page_kind_type;

   typedef enum int {
      TRAFFIC_SLOW_SINK,
      TRAFFIC_SLOW_SOURCE,
      TRAFFIC_FULL_RATE
   } traffic_type;

   typedef struct packed {
      logic       link;
      status_type status;
      logic       clear;
      logic [7:0] hours;
      logic [7:0] minutes;
      logic [7:0] time_fmt;
      logic       connected;
      logic [7:0] model;
   } reading_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_ready   = 1'b0;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_link_active;
   logic [2:0] rsp_frame_status;
   logic       rsp_timeout_clear;
   logic [7:0] rsp_hours;
   logic [7:0] rsp_minutes;
   logic [7:0] rsp_time_24h;
   logic       rsp_connected;
   logic [7:0] rsp_controller_model;

   serial_page_deframer_time_extract_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_link_active      (rsp_link_active),
      .rsp_frame_status     (rsp_frame_status),
      .rsp_timeout_clear    (rsp_timeout_clear),
      .rsp_hours            (rsp_hours),
      .rsp_minutes          (rsp_minutes),
      .rsp_time_24h         (rsp_time_24h),
      .rsp_connected        (rsp_connected),
      .rsp_controller_model (rsp_controller_model),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   // predicted block state
   logic [4:0] page_pos     = POS_FIRST;
   logic [7:0] page_buf [0:PAGE_LEN-1];
   logic [7:0] hours_q      = TIME_DEFAULT;
   logic [7:0] minutes_q    = TIME_DEFAULT;
   logic [7:0] format_q     = FORMAT_RESET;
   logic [7:0] model_q      = HELD_RESET;
   logic       connected_q  = 1'b0;
   logic       link_q       = 1'b0;
   logic [7:0] wanted_model = MODEL_RESET;

   reading_type due_readings [$];
   reading_type head;
   logic [7:0]  page_img [0:PAGE_LEN-1];

   int source_idle_pct = 0;
   int sink_idle_pct   = 0;
   int bytes_sent      = 0;
   int model_settings  = 0;
   int fault_count     = 0;
   int cycles          = 0;
   int n_accepted      = 0;
   int n_bad_end       = 0;
   int n_bad_sum       = 0;
   int n_mismatch      = 0;
   int leftover;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  due_readings.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
   end

   task automatic report(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("MISMATCH at cycle %0d: %s", cycles, msg);
   endtask

   task automatic check_field(input string label, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want)
         report($sformatf("%s expected 0x%02h got 0x%02h", label, want, got));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_readings.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            head = due_readings.pop_front();
            check_field("link_active", head.link, rsp_link_active);
            check_field("frame_status", head.status, rsp_frame_status);
            check_field("timeout_clear", head.clear, rsp_timeout_clear);
            check_field("hours", head.hours, rsp_hours);
            check_field("minutes", head.minutes, rsp_minutes);
            check_field("time_24h", head.time_fmt, rsp_time_24h);
            check_field("connected", head.connected, rsp_connected);
            check_field("controller_model", head.model, rsp_controller_model);
            case (head.status)
               STATUS_ACCEPTED: n_accepted++;
               STATUS_BAD_END:  n_bad_end++;
               STATUS_BAD_SUM:  n_bad_sum++;
               STATUS_MISMATCH: n_mismatch++;
               default: ;
            endcase
         end
      end
   end

   task automatic predict_deframer_byte(input logic [7:0] b);
      reading_type r;
      logic [7:0]  sum;
      int          i;
      r        = '0;
      r.status = STATUS_NONE;
      if (b == START_BYTE) begin
         page_pos = POS_FIRST;
         link_q   = 1'b1;
      end
      page_buf[page_pos] = b;
      if (page_pos == POS_LAST) begin
         sum = '0;
         for (i = POS_MINUTES; i <= POS_SUM_LAST; i++)
            sum = sum + page_buf[i];
         if (page_buf[POS_LAST] != END_BYTE) begin
            r.status = STATUS_BAD_END;
         end else if (8'(8'd0 - sum) != page_buf[POS_CHECK]) begin
            r.status = STATUS_BAD_SUM;
         end else begin
            if (page_buf[POS_PAGE] == PAGE_MODEL)
               model_q = page_buf[POS_MODEL];
            if (model_q != wanted_model) begin
               r.status = STATUS_MISMATCH;
            end else begin
               r.status    = STATUS_ACCEPTED;
               r.clear     = 1'b1;
               connected_q = 1'b1;
               if (page_buf[POS_PAGE] == PAGE_HOURS)
                  hours_q = page_buf[POS_HOURS];
               if (page_buf[POS_PAGE] == PAGE_MINUTES)
                  minutes_q = page_buf[POS_MINUTES];
               if (page_buf[POS_PAGE] == PAGE_FORMAT)
                  format_q = page_buf[POS_FORMAT];
            end
         end
         page_pos = POS_FIRST;
         link_q   = 1'b0;
      end else begin
         page_pos = page_pos + 5'd1;
      end
      r.link      = link_q;
      r.hours     = hours_q;
      r.minutes   = minutes_q;
      r.time_fmt  = format_q;
      r.connected = connected_q;
      r.model     = model_q;
      due_readings.push_back(r);
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < source_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_deframer_byte(b);
      bytes_sent++;
   endtask

   // hold off until every result has been delivered
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_readings.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_expected_model(input logic [7:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      wanted_model = v;
      csr_wr_en   <= 1'b0;
      model_settings++;
   endtask

   task automatic set_traffic(input traffic_type mode);
      case (mode)
         TRAFFIC_SLOW_SINK: begin
            source_idle_pct = 10;
            sink_idle_pct   = 76;
         end
         TRAFFIC_SLOW_SOURCE: begin
            source_idle_pct = 76;
            sink_idle_pct   = 10;
         end
         default: begin
            source_idle_pct = 0;
            sink_idle_pct   = 0;
         end
      endcase
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(255)); while (v == START_BYTE);
      return v;
   endfunction

   function automatic logic [7:0] any_model();
      return plain_byte();
   endfunction

   // fill the check byte; re-draw a filler byte if the check would restart the page
   task automatic seal_page();
      logic [7:0] sum;
      int         i;
      do begin
         sum = '0;
         for (i = POS_MINUTES; i <= POS_SUM_LAST; i++)
            sum = sum + page_img[i];
         page_img[POS_CHECK] = 8'd0 - sum;
         if (page_img[POS_CHECK] == START_BYTE)
            page_img[FILLER_POS] = plain_byte();
      end while (page_img[POS_CHECK] == START_BYTE);
   endtask

   task automatic send_page(input page_kind_type kind);
      int         len;
      int         i;
      logic [7:0] v;
      len = PAGE_LEN;
      page_img[POS_FIRST] = (kind == KIND_NO_START) ? plain_byte() : START_BYTE;
      for (i = 1; i < PAGE_LEN; i++)
         page_img[i] = plain_byte();
      case ($urandom_range(9))
         0, 1:    page_img[POS_PAGE] = PAGE_MODEL;
         2, 3:    page_img[POS_PAGE] = PAGE_HOURS;
         4, 5:    page_img[POS_PAGE] = PAGE_MINUTES;
         6, 7:    page_img[POS_PAGE] = PAGE_FORMAT;
         default: page_img[POS_PAGE] = plain_byte();
      endcase
      if (kind == KIND_WRONG_MODEL)
         page_img[POS_PAGE] = PAGE_MODEL;
      if (page_img[POS_PAGE] == PAGE_MODEL) begin
         if (kind == KIND_WRONG_MODEL)
            do v = plain_byte(); while (v == wanted_model);
         else
            v = wanted_model;
         page_img[POS_MODEL] = v;
      end
      seal_page();
      page_img[POS_LAST] = END_BYTE;
      case (kind)
         KIND_BAD_SUM: begin
            do v = page_img[POS_CHECK] + 8'($urandom_range(1, 255));
            while (v == START_BYTE);
            page_img[POS_CHECK] = v;
         end
         KIND_BAD_END: begin
            do v = plain_byte(); while (v == END_BYTE);
            page_img[POS_LAST] = v;
         end
         KIND_CUT_SHORT:    len = $urandom_range(1, POS_CHECK);
         KIND_START_AT_END: len = POS_LAST;
         default: ;
      endcase
      if (kind == KIND_NOISE) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end else begin
         for (i = 0; i < len; i++)
            send_byte(page_img[i]);
      end
   endtask

   task automatic run_pages(input int budget);
      int            first;
      int            k;
      page_kind_type kind;
      first = bytes_sent;
      k     = 0;
      while (bytes_sent - first < budget) begin
         if (k < NUM_KINDS)
            kind = page_kind_type'(k);
         else if ($urandom_range(99) < 50)
            kind = KIND_GOOD;
         else
            kind = page_kind_type'($urandom_range(1, NUM_KINDS - 1));
         send_page(kind);
         if ($urandom_range(15) == 0)
            drain();
         k++;
      end
   endtask

   // page 0 at the reset model, extreme data bytes, then bytes with no start
   task automatic test_directed_page();
      int i;
      set_traffic(TRAFFIC_FULL_RATE);
      for (i = 0; i < PAGE_LEN; i++)
         page_img[i] = (i % 2 == 1) ? 8'hFF : 8'h00;
      page_img[POS_FIRST] = START_BYTE;
      page_img[POS_PAGE]  = PAGE_MODEL;
      page_img[POS_MODEL] = MODEL_RESET;
      page_img[13]        = END_BYTE;
      seal_page();
      page_img[POS_LAST]  = END_BYTE;
      for (i = 0; i < PAGE_LEN; i++)
         send_byte(page_img[i]);
      send_byte(END_BYTE);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   task automatic test_slow_sink();
      set_traffic(TRAFFIC_SLOW_SINK);
      set_expected_model(8'h00);
      run_pages(180);
      set_expected_model(8'hFF);
      run_pages(180);
   endtask

   task automatic test_slow_source();
      set_traffic(TRAFFIC_SLOW_SOURCE);
      set_expected_model(any_model());
      run_pages(180);
      set_expected_model(MODEL_RESET);
      run_pages(180);
   endtask

   task automatic test_full_rate();
      set_traffic(TRAFFIC_FULL_RATE);
      set_expected_model(any_model());
      run_pages(180);
      set_expected_model(8'h00);
      run_pages(180);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_page();
      test_slow_sink();
      test_slow_source();
      test_full_rate();
      drain();
      repeat (4) @(posedge clock);
      leftover = due_readings.size();
      $display("Sent %0d bytes over three traffic mixes, %0d model settings.",
               bytes_sent, model_settings);
      $display("Page ends: %0d ok, %0d bad end, %0d bad sum, %0d mismatch, %0d missing.",
               n_accepted, n_bad_end, n_bad_sum, n_mismatch, leftover);
      if (fault_count == 0 && leftover == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
